[design/bwu_pkg.sv]
package bwu_pkg;

  localparam int IN_W = 16;
  localparam int OUT_W = 32;
  localparam int MAG_CAP_BITS = 60;
  localparam int SAT_IN_W = 80;

  typedef struct packed {
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] bx;
    logic signed [IN_W-1:0] by_coord;
    logic signed [IN_W-1:0] cx;
    logic signed [IN_W-1:0] cy;
    logic signed [IN_W-1:0] px;
    logic signed [IN_W-1:0] py;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] alpha;
    logic signed [OUT_W-1:0] beta;
    logic signed [OUT_W-1:0] gamma;
    logic                    degenerate;
  } out_item_t;

  function automatic logic [OUT_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    logic [OUT_W-1:0] r;
    hi = (SAT_IN_W'(1) <<< (OUT_W - 1)) - SAT_IN_W'(1);
    lo = -(SAT_IN_W'(1) <<< (OUT_W - 1));
    if (v > hi) begin
      r = hi[OUT_W-1:0];
    end else if (v < lo) begin
      r = lo[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/bwu_if.sv]
interface bwu_in_if;
  import bwu_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface bwu_out_if;
  import bwu_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

[design/bwu_front.sv]
module bwu_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  bwu_in_if.sink                    in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2*COORD_BITS+1:0]   na_mag_o,
  output logic [2*COORD_BITS+1:0]   nb_mag_o,
  output logic [2*COORD_BITS+1:0]   d_mag_o,
  output logic                      sa_o,
  output logic                      sb_o
);
  import bwu_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int PRW = 2 * DW;
  localparam int MW = 2 * CW + 2;
  localparam int XW = PRW + 1;

  logic [IN_W-1:0] raw [8];
  logic signed [CW-1:0] c [8];

  logic v1_q, v2_q, v3_q;
  logic en;

  logic signed [DW-1:0] cax_q, cay_q, bax_q, bay_q, cpx_q, cpy_q, bpx_q, bpy_q, pax_q, pay_q;
  logic signed [PRW-1:0] ar1_q, ar2_q, na1_q, na2_q, nb1_q, nb2_q;
  logic signed [XW-1:0] ar_x, na_x, nb_x;
  logic [MW-1:0] na_mag_q, nb_mag_q, d_mag_q;
  logic sa_q, sb_q;

  assign raw[0] = in_i.payload.ax;
  assign raw[1] = in_i.payload.ay;
  assign raw[2] = in_i.payload.bx;
  assign raw[3] = in_i.payload.by_coord;
  assign raw[4] = in_i.payload.cx;
  assign raw[5] = in_i.payload.cy;
  assign raw[6] = in_i.payload.px;
  assign raw[7] = in_i.payload.py;

  for (genvar i = 0; i < 8; i++) begin : g_coord
    assign c[i] = CW'(raw[i]);
  end

  assign en = !v3_q || out_ready_i;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign ar_x = XW'(ar1_q) - XW'(ar2_q);
  assign na_x = XW'(na1_q) - XW'(na2_q);
  assign nb_x = XW'(nb1_q) - XW'(nb2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      cax_q <= DW'(c[4]) - DW'(c[0]);
      cay_q <= DW'(c[5]) - DW'(c[1]);
      bax_q <= DW'(c[2]) - DW'(c[0]);
      bay_q <= DW'(c[3]) - DW'(c[1]);
      cpx_q <= DW'(c[4]) - DW'(c[6]);
      cpy_q <= DW'(c[5]) - DW'(c[7]);
      bpx_q <= DW'(c[2]) - DW'(c[6]);
      bpy_q <= DW'(c[3]) - DW'(c[7]);
      pax_q <= DW'(c[6]) - DW'(c[0]);
      pay_q <= DW'(c[7]) - DW'(c[1]);
      ar1_q <= cax_q * bay_q;
      ar2_q <= cay_q * bax_q;
      na1_q <= cpx_q * bpy_q;
      na2_q <= cpy_q * bpx_q;
      nb1_q <= cax_q * pay_q;
      nb2_q <= cay_q * pax_q;
      na_mag_q <= na_x[XW-1] ? MW'(-na_x) : MW'(na_x);
      nb_mag_q <= nb_x[XW-1] ? MW'(-nb_x) : MW'(nb_x);
      d_mag_q <= ar_x[XW-1] ? MW'(-ar_x) : MW'(ar_x);
      sa_q <= na_x[XW-1] != ar_x[XW-1];
      sb_q <= nb_x[XW-1] != ar_x[XW-1];
    end
  end

  assign out_valid_o = v3_q;
  assign na_mag_o = na_mag_q;
  assign nb_mag_o = nb_mag_q;
  assign d_mag_o = d_mag_q;
  assign sa_o = sa_q;
  assign sb_o = sb_q;

endmodule

[design/bwu_fifo.sv]
module bwu_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);

  logic [W-1:0] mem_q [2];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o = mem_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

[design/bwu_div_pipe.sv]
module bwu_div_pipe #(
  parameter int COORD_BITS = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2*COORD_BITS+1:0]   na_mag_i,
  input  logic [2*COORD_BITS+1:0]   nb_mag_i,
  input  logic [2*COORD_BITS+1:0]   d_mag_i,
  input  logic                      sa_i,
  input  logic                      sb_i,
  bwu_out_if.source                 out_o
);
  import bwu_pkg::*;

  localparam int F = WEIGHT_FRAC_BITS;
  localparam int MW = 2 * COORD_BITS + 2;
  localparam int QW = MW + F;
  localparam int NS = QW;
  localparam int QWC = (QW > MAG_CAP_BITS) ? MAG_CAP_BITS : QW;
  localparam int GX = QWC + 3;

  logic en;
  logic v_q [NS+1];
  logic [QW-1:0] nqa_q [NS+1];
  logic [QW-1:0] nqb_q [NS+1];
  logic [MW-1:0] ra_q [NS+1];
  logic [MW-1:0] rb_q [NS+1];
  logic [MW-1:0] d_q [NS+1];
  logic sa_q [NS+1];
  logic sb_q [NS+1];
  logic dg_q [NS+1];

  logic out_valid_q;
  out_item_t out_q;

  logic [QWC-1:0] qa_c, qb_c;
  logic signed [GX-1:0] am, bm, al, be, ga;

  assign en = !out_valid_q || out_o.ready;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nqa_q[0] <= {na_mag_i, {F{1'b0}}};
      nqb_q[0] <= {nb_mag_i, {F{1'b0}}};
      ra_q[0] <= '0;
      rb_q[0] <= '0;
      d_q[0] <= d_mag_i;
      sa_q[0] <= sa_i;
      sb_q[0] <= sb_i;
      dg_q[0] <= d_mag_i == '0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [MW:0] ta, tb;
    logic ge_a, ge_b;

    assign ta = {ra_q[k], nqa_q[k][QW-1]};
    assign tb = {rb_q[k], nqb_q[k][QW-1]};
    assign ge_a = ta >= {1'b0, d_q[k]};
    assign ge_b = tb >= {1'b0, d_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ra_q[k+1] <= ge_a ? MW'(ta - {1'b0, d_q[k]}) : ta[MW-1:0];
        rb_q[k+1] <= ge_b ? MW'(tb - {1'b0, d_q[k]}) : tb[MW-1:0];
        nqa_q[k+1] <= {nqa_q[k][QW-2:0], ge_a};
        nqb_q[k+1] <= {nqb_q[k][QW-2:0], ge_b};
        d_q[k+1] <= d_q[k];
        sa_q[k+1] <= sa_q[k];
        sb_q[k+1] <= sb_q[k];
        dg_q[k+1] <= dg_q[k];
      end
    end
  end

  if (QW > MAG_CAP_BITS) begin : g_cap
    assign qa_c = (|nqa_q[NS][QW-1:QWC]) ? {QWC{1'b1}} : nqa_q[NS][QWC-1:0];
    assign qb_c = (|nqb_q[NS][QW-1:QWC]) ? {QWC{1'b1}} : nqb_q[NS][QWC-1:0];
  end else begin : g_nocap
    assign qa_c = nqa_q[NS][QWC-1:0];
    assign qb_c = nqb_q[NS][QWC-1:0];
  end

  assign am = GX'(qa_c);
  assign bm = GX'(qb_c);
  assign al = sa_q[NS] ? -am : am;
  assign be = sb_q[NS] ? -bm : bm;
  assign ga = (GX'(1) <<< F) - al - be;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.degenerate <= dg_q[NS];
      out_q.alpha <= dg_q[NS] ? '0 : sat32(SAT_IN_W'(al));
      out_q.beta <= dg_q[NS] ? '0 : sat32(SAT_IN_W'(be));
      out_q.gamma <= dg_q[NS] ? '0 : sat32(SAT_IN_W'(ga));
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.degenerate |->
      out_q.alpha == '0 && out_q.beta == '0 && out_q.gamma == '0)
    else $error("Degenerate transaction carries nonzero weights.");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_q))
    else $error("Output register changed while stalled.");

  a_last_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v_q[NS] |=> out_valid_q)
    else $error("Transaction lost at the output register.");

endmodule

[design/barycentric_weight_unit_top.sv]
// A transaction passes the front end's difference, product and magnitude registers, the
// queue, the divider stages and the output register. One transaction per cycle is taken
// unless out_o stalls; the divider pipeline computes one quotient bit per stage.
// A two-entry queue sits between the cross-product front end and the divider pipeline.
// Reset is asynchronous and active low; it clears all valid flags and queue pointers.
module barycentric_weight_unit_top #(
  parameter int COORD_BITS = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bwu_in_if.sink    in_i,
  bwu_out_if.source out_o
);
  import bwu_pkg::*;

  localparam int MW = 2 * COORD_BITS + 2;
  localparam int EW = 3 * MW + 2;

  logic f_valid, f_ready;
  logic [MW-1:0] f_na, f_nb, f_d;
  logic f_sa, f_sb;
  logic q_valid, q_ready;
  logic [EW-1:0] q_data;

  bwu_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_valid_o(f_valid),
    .out_ready_i(f_ready),
    .na_mag_o   (f_na),
    .nb_mag_o   (f_nb),
    .d_mag_o    (f_d),
    .sa_o       (f_sa),
    .sb_o       (f_sb)
  );

  bwu_fifo #(
    .W(EW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .in_data_i  ({f_sa, f_sb, f_na, f_nb, f_d}),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready),
    .out_data_o (q_data)
  );

  bwu_div_pipe #(
    .COORD_BITS      (COORD_BITS),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(q_valid),
    .in_ready_o(q_ready),
    .na_mag_i  (q_data[3*MW-1:2*MW]),
    .nb_mag_i  (q_data[2*MW-1:MW]),
    .d_mag_i   (q_data[MW-1:0]),
    .sa_i      (q_data[3*MW+1]),
    .sb_i      (q_data[3*MW]),
    .out_o     (out_o)
  );

endmodule

[tb/sv/bwu_weight_checker.sv]
module bwu_weight_checker
  import bwu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  bwu_in_if.sink    in_mon,
  bwu_out_if.sink   out_mon,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int FRAC = 16;
  localparam logic [63:0] MAG_CAP = (64'd1 << MAG_CAP_BITS) - 64'd1;

  out_item_t weights_q[$];
  int fails;

  function automatic longint signed weight_quotient(longint signed num, longint signed den);
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] r;
    bit capped;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = n / d;
    r = n % d;
    capped = q > MAG_CAP;
    for (int i = 0; i < FRAC && !capped; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
      if (q > MAG_CAP) capped = 1;
    end
    if (capped) q = MAG_CAP;
    if ((num < 0) != (den < 0)) return -longint'(q);
    return longint'(q);
  endfunction

  function automatic logic [OUT_W-1:0] clamp32(longint signed v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic out_item_t predict_weights(in_item_t it);
    longint signed ax, ay, bx, by, cx, cy, px, py, area, na, nb, al, be, ga;
    out_item_t o;
    ax = it.ax; ay = it.ay; bx = it.bx; by = it.by_coord;
    cx = it.cx; cy = it.cy; px = it.px; py = it.py;
    area = (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
    na = (cx - px) * (by - py) - (cy - py) * (bx - px);
    nb = (cx - ax) * (py - ay) - (cy - ay) * (px - ax);
    o = '0;
    if (area == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    al = weight_quotient(na, area);
    be = weight_quotient(nb, area);
    ga = (64'sd1 <<< FRAC) - al - be;
    o.alpha = clamp32(al);
    o.beta = clamp32(be);
    o.gamma = clamp32(ga);
    return o;
  endfunction

  assign fail_count_o = fails;
  assign pending_o = weights_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_w;
    if (!rst_ni) begin
      fails = 0;
      weights_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) weights_q.push_back(predict_weights(in_mon.payload));
      if (out_mon.valid && out_mon.ready) begin
        if (weights_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected transaction, actual %p", $time, out_mon.payload);
        end else begin
          exp_w = weights_q.pop_front();
          if (exp_w !== out_mon.payload) begin
            fails++;
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_w, out_mon.payload);
          end
        end
      end
    end
  end

endmodule

[tb/sv/tb.sv]
module tb;
  import bwu_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off;
  bit hold_req;
  bit stim_done;
  int quiet_cycles = 0;

  bwu_in_if in_ch();
  bwu_out_if out_ch();

  barycentric_weight_unit_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  bwu_weight_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic signed [IN_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_query();
    in_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 3))
      0: begin
        it.ax = pick_coord(); it.ay = pick_coord(); it.bx = pick_coord();
        it.by_coord = pick_coord(); it.cx = pick_coord(); it.cy = pick_coord();
        it.px = pick_coord(); it.py = pick_coord();
      end
      1: begin
        it.bx = it.ax + 16'($urandom_range(0, 40));
        it.by_coord = it.ay + 16'($urandom_range(0, 40));
        it.cx = it.ax + 16'($urandom_range(0, 40));
        it.cy = it.ay + 16'($urandom_range(0, 40));
        it.px = it.ax + 16'($urandom_range(0, 60)) - 16'sd10;
        it.py = it.ay + 16'($urandom_range(0, 60)) - 16'sd10;
      end
      2: begin
        it.cx = it.ax + (it.bx - it.ax) * 16'($urandom_range(0, 2));
        it.cy = it.ay + (it.by_coord - it.ay) * 16'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) begin it.bx = it.ax; it.by_coord = it.ay; end
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic send_query(in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("FAIL barycentric_weight_unit_top");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    hold_req = 0;
    stim_done = 0;
    send_idle_pct = 17;
    recv_idle_pct = 46;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // Extremes, unit triangle, point on vertices and degenerate triangles.
    send_query('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                 16'sh7fff, 16'sh7fff});
    send_query('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                 16'sh8000, 16'sh8000});
    send_query('{0, 0, 16, 0, 0, 16, 4, 4});
    send_query('{0, 0, 16, 0, 0, 16, 0, 0});
    send_query('{0, 0, 16, 0, 0, 16, 16'sh7fff, 16'sh8000});
    send_query('{0, 0, 1, 0, 0, 1, 16'sh8000, 16'sh7fff});
    send_query('{5, 5, 5, 5, 5, 5, 1, 2});
    send_query('{0, 0, 10, 10, 20, 20, 3, 1});
    send_query('{16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff,
                 16'shffff, 16'shffff});
    send_query('{0, 0, 0, 16, 16, 0, 8, 8});
    for (int i = 0; i < 840; i++) begin
      if (i == 280) begin send_idle_pct = 46; recv_idle_pct = 17; end
      if (i == 560) begin send_idle_pct = 0; recv_idle_pct = 0; end
      if (i == 600) hold_req = 1;
      send_query(random_query());
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // The receiver holds off for a long stretch while the sender keeps offering transactions.
  initial begin
    wait (hold_req);
    @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    wait (stim_done);
    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS barycentric_weight_unit_top");
    end else begin
      $display("FAIL barycentric_weight_unit_top");
    end
    $finish;
  end

endmodule

[filelist.f]
design/bwu_pkg.sv
design/bwu_if.sv
design/bwu_front.sv
design/bwu_fifo.sv
design/bwu_div_pipe.sv
design/barycentric_weight_unit_top.sv
tb/sv/bwu_weight_checker.sv
tb/sv/tb.sv
